[sv/lspf_pkg.sv]
// ----------------------------------------------------------------------------
// lspf_pkg
// Shared constants and types for the LCD subpixel glyph pixel filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lspf_pkg;

    // Default bound on bitmap width and rows
    localparam int MAX_BITMAP_DIM_DEF = 4096;

    // Configuration register indexes
    localparam int        CFG_IDX_W          = 2;
    localparam logic [1:0] CFG_RENDER_MODE   = 2'd0;
    localparam logic [1:0] CFG_SUBPIXEL_ORDER = 2'd1;
    localparam logic [1:0] CFG_BITMAP_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_BITMAP_ROWS   = 2'd3;
    localparam int        CFG_DATA_W         = 12;

    // Render modes; code 3 is unused and renders opaque black
    localparam logic [1:0] MODE_MONO = 2'd0;
    localparam logic [1:0] MODE_GREY = 2'd1;
    localparam logic [1:0] MODE_LCD  = 2'd2;

    localparam int COORD_IN_W = 12;
    localparam int SAMPLE_W   = 8;
    localparam int NUM_TAPS   = 7;
    localparam int NUM_CHAN   = 3;
    localparam int PIXEL_W    = 32;

    // Filter sum peaks at 9 * 255 = 2295
    localparam int SUM_W = 12;

    // floor(x / 9) == (x * 7282) >> 16 for x <= 2295
    localparam int              RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
    localparam int              DIV9_SHIFT  = 16;

    localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [SAMPLE_W-1:0] GREY_FULL    = 8'd255;

    typedef logic [NUM_TAPS-1:0][SAMPLE_W-1:0] t_sample_win;
    typedef logic [NUM_CHAN-1:0][SUM_W-1:0]    t_sum_vec;
    typedef logic [NUM_CHAN-1:0][SAMPLE_W-1:0] t_chan_vec;

    // Stage load enables from the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_load;

endpackage : lspf_pkg

`default_nettype wire

[sv/lspf_datapath.sv]
// ----------------------------------------------------------------------------
// lspf_datapath
// Four register stages: bounds mask and grey select, 1-2-3-2-1 filter sums,
// reciprocal divide by nine, pixel word packing.
// ----------------------------------------------------------------------------
`default_nettype none

module lspf_datapath #(
    parameter int MAX_BITMAP_DIM = lspf_pkg::MAX_BITMAP_DIM_DEF,
    localparam int DW = $clog2(MAX_BITMAP_DIM + 1)
) (
    input  wire logic                                i_clk,
    input  wire lspf_pkg::t_stage_load               i_load,
    input  wire logic [1:0]                          i_render_mode,
    input  wire logic [1:0]                          i_subpixel_order,
    input  wire logic [DW-1:0]                       i_eff_width,
    input  wire logic [DW-1:0]                       i_eff_rows,
    input  wire logic [lspf_pkg::COORD_IN_W-1:0]     i_pixel_x,
    input  wire logic [lspf_pkg::COORD_IN_W-1:0]     i_pixel_y,
    input  wire lspf_pkg::t_sample_win               i_win,
    output logic [lspf_pkg::PIXEL_W-1:0]             o_pixel_rgba
);

    // Signed coordinate width: holds 3*4095+1 and the largest bound
    localparam int CW = (DW + 1 > 15) ? DW + 1 : 15;
    localparam int PROD_W = lspf_pkg::SUM_W + lspf_pkg::RECIP_W;

    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] px3;
    logic signed [CW-1:0] py3;
    logic signed [CW-1:0] lim_w;
    logic signed [CW-1:0] lim_r;
    logic signed [CW-1:0] col [lspf_pkg::NUM_TAPS];
    logic signed [CW-1:0] row [lspf_pkg::NUM_TAPS];
    logic                 vertical;
    lspf_pkg::t_sample_win n_s1_win;
    logic [lspf_pkg::SAMPLE_W-1:0] n_s1_grey;
    logic                          n_s1_lcd;
    logic [2:0]                    mono_bit;

    lspf_pkg::t_sample_win         r_s1_win;
    logic [lspf_pkg::SAMPLE_W-1:0] r_s1_grey;
    logic                          r_s1_lcd;
    logic                          r_s1_bgr;

    lspf_pkg::t_sum_vec            n_s2_sum;
    lspf_pkg::t_sum_vec            r_s2_sum;
    logic [lspf_pkg::SAMPLE_W-1:0] r_s2_grey;
    logic                          r_s2_lcd;
    logic                          r_s2_bgr;

    logic [PROD_W-1:0]             prod [lspf_pkg::NUM_CHAN];
    lspf_pkg::t_chan_vec           n_s3_q;
    lspf_pkg::t_chan_vec           r_s3_q;
    logic [lspf_pkg::SAMPLE_W-1:0] r_s3_grey;
    logic                          r_s3_lcd;
    logic                          r_s3_bgr;

    logic [lspf_pkg::PIXEL_W-1:0]  n_s4_word;
    logic [lspf_pkg::PIXEL_W-1:0]  r_s4_word;

    // Stage 1: sample positions, bounds mask, grey value for mono/antialias
    always_comb begin
        vertical = i_subpixel_order[1];
        px       = $signed(CW'(i_pixel_x));
        py       = $signed(CW'(i_pixel_y));
        px3      = (px <<< 1) + px;
        py3      = (py <<< 1) + py;
        lim_w    = $signed(CW'(i_eff_width));
        lim_r    = $signed(CW'(i_eff_rows));
        for (int k = 0; k < lspf_pkg::NUM_TAPS; k++) begin
            col[k] = vertical ? px : px3 + CW'(k - 5);
            row[k] = vertical ? py3 + CW'(k - 5) : py;
            if (!col[k][CW-1] && (col[k] < lim_w) && !row[k][CW-1] && (row[k] < lim_r)) begin
                n_s1_win[k] = i_win[k];
            end else begin
                n_s1_win[k] = '0;
            end
        end

        mono_bit = 3'd7 - i_pixel_x[2:0];
        n_s1_lcd = 1'b0;
        unique case (i_render_mode)
            lspf_pkg::MODE_MONO: begin
                n_s1_grey = i_win[0][mono_bit] ? lspf_pkg::GREY_FULL : '0;
            end
            lspf_pkg::MODE_GREY: begin
                n_s1_grey = i_win[0];
            end
            lspf_pkg::MODE_LCD: begin
                n_s1_grey = '0;
                n_s1_lcd  = 1'b1;
            end
            default: begin
                n_s1_grey = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load.s1) begin
            r_s1_win  <= n_s1_win;
            r_s1_grey <= n_s1_grey;
            r_s1_lcd  <= n_s1_lcd;
            r_s1_bgr  <= i_subpixel_order[0];
        end
    end

    // Stage 2: three 1-2-3-2-1 sums
    always_comb begin
        for (int c = 0; c < lspf_pkg::NUM_CHAN; c++) begin
            n_s2_sum[c] = lspf_pkg::SUM_W'(r_s1_win[c])
                        + (lspf_pkg::SUM_W'(r_s1_win[c+1]) << 1)
                        + (lspf_pkg::SUM_W'(r_s1_win[c+2]) << 1)
                        + lspf_pkg::SUM_W'(r_s1_win[c+2])
                        + (lspf_pkg::SUM_W'(r_s1_win[c+3]) << 1)
                        + lspf_pkg::SUM_W'(r_s1_win[c+4]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.s2) begin
            r_s2_sum  <= n_s2_sum;
            r_s2_grey <= r_s1_grey;
            r_s2_lcd  <= r_s1_lcd;
            r_s2_bgr  <= r_s1_bgr;
        end
    end

    // Stage 3: divide by nine via reciprocal multiply
    always_comb begin
        for (int c = 0; c < lspf_pkg::NUM_CHAN; c++) begin
            prod[c]   = PROD_W'(r_s2_sum[c]) * PROD_W'(lspf_pkg::DIV9_RECIP);
            n_s3_q[c] = prod[c][lspf_pkg::DIV9_SHIFT +: lspf_pkg::SAMPLE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.s3) begin
            r_s3_q    <= n_s3_q;
            r_s3_grey <= r_s2_grey;
            r_s3_lcd  <= r_s2_lcd;
            r_s3_bgr  <= r_s2_bgr;
        end
    end

    // Stage 4: channel order and packing
    always_comb begin
        if (!r_s3_lcd) begin
            n_s4_word = {r_s3_grey, r_s3_grey, r_s3_grey, lspf_pkg::ALPHA_OPAQUE};
        end else if (r_s3_bgr) begin
            n_s4_word = {r_s3_q[2], r_s3_q[1], r_s3_q[0], lspf_pkg::ALPHA_OPAQUE};
        end else begin
            n_s4_word = {r_s3_q[0], r_s3_q[1], r_s3_q[2], lspf_pkg::ALPHA_OPAQUE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.s4) begin
            r_s4_word <= n_s4_word;
        end
    end

    assign o_pixel_rgba = r_s4_word;

endmodule : lspf_datapath

`default_nettype wire

[sv/lcd_subpixel_glyph_pixel_filter_top.sv]
// ----------------------------------------------------------------------------
// lcd_subpixel_glyph_pixel_filter_top - glyph coverage to RGBA pixel filter
// Throughput: one beat per cycle while the output is not stalled; empty stages fill while the output stalls.
// Reset: synchronous active low, clears valid bits and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_subpixel_glyph_pixel_filter_top #(
    parameter int MAX_BITMAP_DIM = lspf_pkg::MAX_BITMAP_DIM_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config write port
    input  wire logic                                i_cfg_we,
    input  wire logic [lspf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lspf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [lspf_pkg::COORD_IN_W-1:0]     i_pixel_x,
    input  wire logic [lspf_pkg::COORD_IN_W-1:0]     i_pixel_y,
    input  wire logic [lspf_pkg::SAMPLE_W-1:0]       i_sample_0,
    input  wire logic [lspf_pkg::SAMPLE_W-1:0]       i_sample_1,
    input  wire logic [lspf_pkg::SAMPLE_W-1:0]       i_sample_2,
    input  wire logic [lspf_pkg::SAMPLE_W-1:0]       i_sample_3,
    input  wire logic [lspf_pkg::SAMPLE_W-1:0]       i_sample_4,
    input  wire logic [lspf_pkg::SAMPLE_W-1:0]       i_sample_5,
    input  wire logic [lspf_pkg::SAMPLE_W-1:0]       i_sample_6,
    // output channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [lspf_pkg::PIXEL_W-1:0]             o_pixel_rgba
);

    localparam int DW = $clog2(MAX_BITMAP_DIM + 1);
    localparam int LW = (DW > lspf_pkg::CFG_DATA_W) ? DW : lspf_pkg::CFG_DATA_W;
    localparam int NSTG = 4;

    logic [1:0]      r_render_mode;
    logic [1:0]      r_subpixel_order;
    logic [DW-1:0]   r_eff_width;
    logic [DW-1:0]   r_eff_rows;
    logic [LW-1:0]   cfg_ext;
    logic [DW-1:0]   cfg_dim;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] ready;
    lspf_pkg::t_stage_load  load;
    lspf_pkg::t_sample_win  win;

    // Dimension registers hold the bound already limited to MAX_BITMAP_DIM
    always_comb begin
        cfg_ext = LW'(i_cfg_data);
        cfg_dim = (cfg_ext > LW'(MAX_BITMAP_DIM)) ? DW'(MAX_BITMAP_DIM) : DW'(cfg_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_render_mode    <= '0;
            r_subpixel_order <= '0;
            r_eff_width      <= '0;
            r_eff_rows       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lspf_pkg::CFG_RENDER_MODE:    r_render_mode    <= i_cfg_data[1:0];
                lspf_pkg::CFG_SUBPIXEL_ORDER: r_subpixel_order <= i_cfg_data[1:0];
                lspf_pkg::CFG_BITMAP_WIDTH:   r_eff_width      <= cfg_dim;
                lspf_pkg::CFG_BITMAP_ROWS:    r_eff_rows       <= cfg_dim;
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on this cycle
    always_comb begin
        ready[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ready[k] = !r_vld[k] || ready[k+1];
        end
        load.s1 = ready[0];
        load.s2 = ready[1];
        load.s3 = ready[2];
        load.s4 = ready[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ready[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (ready[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !ready[0];
    assign o_valid = r_vld[NSTG-1];
    assign win     = {i_sample_6, i_sample_5, i_sample_4, i_sample_3,
                      i_sample_2, i_sample_1, i_sample_0};

    lspf_datapath #(
        .MAX_BITMAP_DIM (MAX_BITMAP_DIM)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_load           (load),
        .i_render_mode    (r_render_mode),
        .i_subpixel_order (r_subpixel_order),
        .i_eff_width      (r_eff_width),
        .i_eff_rows       (r_eff_rows),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_win            (win),
        .o_pixel_rgba     (o_pixel_rgba)
    );

    // Input side only backs up when every stage holds a beat and output stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled with a free pipeline stage");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_rgba[7:0] == lspf_pkg::ALPHA_OPAQUE))
        else $error("alpha byte not opaque");

    a_grey_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_render_mode != lspf_pkg::MODE_LCD)) |->
        ((o_pixel_rgba[31:24] == o_pixel_rgba[23:16]) &&
         (o_pixel_rgba[23:16] == o_pixel_rgba[15:8])))
        else $error("grey pixel with unequal channels");

    a_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && i_stall) |=> r_vld[NSTG-1])
        else $error("stalled output beat dropped");

endmodule : lcd_subpixel_glyph_pixel_filter_top

`default_nettype wire
